### design/bfha_pkg.sv
// Package for the best-fit heap allocator.
// Holds sizes, status codes and the request, result and table entry types.
// No dependencies.
`default_nettype none

package bfha_pkg;

  localparam int unsigned HEAP_BYTES   = 256 * 1024;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_BLOCKS   = 64;

  localparam int unsigned FLD_W = 18;                        // request and result offsets
  localparam int unsigned ADR_W = $clog2(HEAP_BYTES);
  localparam int unsigned TBL_W = (ADR_W > FLD_W) ? ADR_W : FLD_W;
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NOFIT    = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [FLD_W-1:0]   request_size;
    logic [FLD_W-1:0]   release_offset;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FLD_W-1:0]   payload_offset;
  } rsp_t;

  typedef struct packed {
    logic               used;
    logic [TBL_W-1:0]   payload;
    logic [TBL_W-1:0]   start;
  } entry_t;

endpackage

`default_nettype wire

### design/best_fit_heap_allocator_top.sv
// Best-fit heap allocator: block table in a single-port-write memory, one sequencer.
// Depends on bfha_pkg.
`default_nettype none

// A request is taken when start is high and busy is low; one result follows, shown on rsp_o
// for one cycle with done_o high, and it cannot be held off. The block table sits in a
// 64-entry memory with one registered read port and one write port, and every request but
// a zero-size allocate walks it one entry a cycle. The walk of a free request also
// coalesces free neighbors in place. After the walk of an allocate request, a split first
// shifts the tail up by one entry when the best entry is not the last one, and then writes
// the best entry and the new free entry; a zero size is answered from idle with no walk.
// After reset, busy stays high for one cycle while the first table entry is written.
module best_fit_heap_allocator_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire bfha_pkg::req_t req_i,
  output logic              done_o,
  output bfha_pkg::rsp_t    rsp_o
);
  import bfha_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_WR_BEST, S_WR_NEW, S_FLUSH
  } state_e;

  localparam logic [TBL_W-1:0] HDR = TBL_W'(HEADER_BYTES);

  state_e              state_q, state_d;
  req_type_e           op_q, op_d;
  logic [TBL_W-1:0]    size_q, size_d;
  logic [FLD_W-1:0]    ofs_q, ofs_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;
  logic                dv_q, dv_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  entry_t              best_q, best_d;
  entry_t              acc_q, acc_d;
  logic                acc_v_q, acc_v_d;
  logic [CNT_W-1:0]    wr_idx_q, wr_idx_d;
  logic                split_q, split_d;
  logic [TBL_W-1:0]    rest_q, rest_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;

  entry_t              mem [MAX_BLOCKS];
  entry_t              rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                we;
  logic [IDX_W-1:0]    wa;
  entry_t              wd;

  entry_t              ev;
  logic [TBL_W:0]      ev_ofs;
  logic [TBL_W:0]      best_ofs;
  logic [TBL_W-1:0]    rest_w;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign ev_ofs   = {1'b0, rd_data_q.start} + {1'b0, HDR};
  assign best_ofs = {1'b0, best_q.start} + {1'b0, HDR};
  assign rest_w   = best_q.payload - size_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    size_d     = size_q;
    ofs_d      = ofs_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    ev_idx_d   = ev_idx_q;
    dv_d       = 1'b0;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    acc_d      = acc_q;
    acc_v_d    = acc_v_q;
    wr_idx_d   = wr_idx_q;
    split_d    = split_q;
    rest_d     = rest_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_addr    = rd_idx_q[IDX_W-1:0];
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ev         = rd_data_q;

    unique case (state_q)
      S_INIT: begin
        we            = 1'b1;
        wa            = '0;
        wd.used       = 1'b0;
        wd.payload    = TBL_W'(HEAP_BYTES - HEADER_BYTES);
        wd.start      = '0;
        cnt_d         = CNT_W'(1);
        state_d       = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          op_d     = req_i.req_type;
          size_d   = TBL_W'(req_i.request_size);
          ofs_d    = req_i.release_offset;
          rd_idx_d = '0;
          found_d  = 1'b0;
          acc_v_d  = 1'b0;
          wr_idx_d = '0;
          if (req_i.req_type == REQ_ALLOC && req_i.request_size == '0) begin
            done_d = 1'b1;
            rsp_d  = '{status: ST_ZERO, payload_offset: '0};
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue the next read while the previous entry is evaluated
        if (rd_idx_q < cnt_q) begin
          dv_d     = 1'b1;
          ev_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (dv_q) begin
          if (op_q == REQ_ALLOC) begin
            if (!rd_data_q.used && rd_data_q.payload >= size_q &&
                (!found_q || rd_data_q.payload < best_q.payload)) begin
              found_d    = 1'b1;
              best_idx_d = ev_idx_q;
              best_d     = rd_data_q;
            end
          end else begin
            if (!found_q && ev_ofs == {{(TBL_W+1-FLD_W){1'b0}}, ofs_q}) begin
              ev.used = 1'b0;
              found_d = 1'b1;
            end
            // compact in place: merge free neighbors into the held entry
            if (acc_v_q && !acc_q.used && !ev.used) begin
              acc_d.payload = acc_q.payload + HDR + ev.payload;
            end else begin
              if (acc_v_q) begin
                we       = 1'b1;
                wa       = wr_idx_q[IDX_W-1:0];
                wd       = acc_q;
                wr_idx_d = wr_idx_q + CNT_W'(1);
              end
              acc_d   = ev;
              acc_v_d = 1'b1;
            end
          end
        end else if (rd_idx_q == cnt_q) begin
          if (op_q == REQ_FREE) begin
            state_d = S_FLUSH;
          end else if (!found_q) begin
            done_d  = 1'b1;
            rsp_d   = '{status: ST_NOFIT, payload_offset: '0};
            state_d = S_IDLE;
          end else begin
            rest_d  = rest_w;
            split_d = (rest_w > HDR) && (cnt_q < CNT_W'(MAX_BLOCKS));
            rd_idx_d = cnt_q - CNT_W'(1);
            if ((rest_w > HDR) && (cnt_q < CNT_W'(MAX_BLOCKS)) &&
                ({1'b0, best_idx_q} + CNT_W'(1) < cnt_q)) begin
              state_d = S_SHIFT;
            end else begin
              state_d = S_WR_BEST;
            end
          end
        end
      end

      S_SHIFT: begin
        // move the tail up by one entry, highest index first
        if (rd_idx_q > {1'b0, best_idx_q}) begin
          dv_d     = 1'b1;
          ev_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q - CNT_W'(1);
        end
        if (dv_q) begin
          we = 1'b1;
          wa = ev_idx_q + IDX_W'(1);
          wd = rd_data_q;
        end else if (rd_idx_q == {1'b0, best_idx_q}) begin
          state_d = S_WR_BEST;
        end
      end

      S_WR_BEST: begin
        we         = 1'b1;
        wa         = best_idx_q;
        wd         = best_q;
        wd.used    = 1'b1;
        if (split_q) begin
          wd.payload = size_q;
          state_d    = S_WR_NEW;
        end else begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_OK, payload_offset: best_ofs[FLD_W-1:0]};
          state_d = S_IDLE;
        end
      end

      S_WR_NEW: begin
        we         = 1'b1;
        wa         = best_idx_q + IDX_W'(1);
        wd.used    = 1'b0;
        wd.payload = rest_q - HDR;
        wd.start   = best_q.start + HDR + size_q;
        cnt_d      = cnt_q + CNT_W'(1);
        done_d     = 1'b1;
        rsp_d      = '{status: ST_OK, payload_offset: best_ofs[FLD_W-1:0]};
        state_d    = S_IDLE;
      end

      S_FLUSH: begin
        we      = 1'b1;
        wa      = wr_idx_q[IDX_W-1:0];
        wd      = acc_q;
        cnt_d   = wr_idx_q + CNT_W'(1);
        done_d  = 1'b1;
        rsp_d   = '{status: (found_q ? ST_OK : ST_UNKNOWN), payload_offset: '0};
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= CNT_W'(1);
      dv_q       <= 1'b0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      acc_v_q    <= 1'b0;
      split_q    <= 1'b0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      rsp_q      <= '{status: ST_OK, payload_offset: '0};
      op_q       <= REQ_ALLOC;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      dv_q       <= dv_d;
      done_q     <= done_d;
      found_q    <= found_d;
      acc_v_q    <= acc_v_d;
      split_q    <= split_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      rsp_q      <= rsp_d;
      op_q       <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    ofs_q      <= ofs_d;
    ev_idx_q   <= ev_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    acc_q      <= acc_d;
    rest_q     <= rest_d;
  end

endmodule

`default_nettype wire
